// ===== rtl/drvg_pkg.sv =====
// ----------------------------------------------------------------------------
// drvg_pkg: shared definitions for the visibility grid
// Request codes, tile levels, register indexes and the command and status
// records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package drvg_pkg;

   localparam int REQ_W   = 3;
   localparam int POS_W   = 8;
   localparam int RAD_W   = 8;
   localparam int LVL_W   = 2;
   localparam int CSR_W   = 9;
   localparam int CSR_IDX_W = 1;

   localparam logic [REQ_W-1:0] REQ_BEGIN_FRAME = 3'd0;
   localparam logic [REQ_W-1:0] REQ_REVEAL      = 3'd1;
   localparam logic [REQ_W-1:0] REQ_QUERY       = 3'd2;
   localparam logic [REQ_W-1:0] REQ_REVEAL_ALL  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CLEAR       = 3'd4;

   localparam logic [LVL_W-1:0] LVL_UNEXPLORED = 2'd0;
   localparam logic [LVL_W-1:0] LVL_EXPLORED   = 2'd1;
   localparam logic [LVL_W-1:0] LVL_VISIBLE    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 1'd1;

   localparam logic [CSR_W-1:0] MAP_SIZE_RESET = 9'd256;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_REV_SETUP,
      ST_REV_ROW,
      ST_REV_SQRT,
      ST_REV_WAIT,
      ST_REV_WRITE,
      ST_Q_READ,
      ST_Q_RESP
   } state_type;

   typedef enum logic [1:0] {
      WM_NONE,
      WM_CLEAR,
      WM_FILL,
      WM_DEMOTE
   } wmode_type;

   typedef enum logic [2:0] {
      ROW_HOLD,
      ROW_ZERO,
      ROW_LOAD_POS,
      ROW_LOAD_LO,
      ROW_INC
   } row_op_type;

   typedef struct packed {
      logic       accept;
      row_op_type row_op;
      logic       rd_en;
      wmode_type  wmode;
      logic       rev_setup;
      logic       dr_load;
      logic       sqrt_start;
      logic       rev_write;
      logic       rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic rev_done;
      logic sqrt_busy;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/drvg_sqrt.sv =====
// ----------------------------------------------------------------------------
// drvg_sqrt: iterative integer square root
// Takes a 16-bit radicand and produces its 8-bit floor root, one result bit
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module drvg_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] radicand,
   output logic             busy,
   output logic [7:0]       root
);

   logic        busy_ff, busy_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [15:0] x_ff, x_in;
   logic [15:0] res_ff, res_in;
   logic [15:0] bit_val;
   logic [16:0] trial;

   always_comb begin
      bit_val = 16'h4000 >> {cnt_ff, 1'b0};
      trial   = {1'b0, res_ff} + {1'b0, bit_val};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         x_in    = radicand;
         res_in  = 16'd0;
      end else if (busy_ff) begin
         if ({1'b0, x_ff} >= trial) begin
            x_in   = x_ff - trial[15:0];
            res_in = (res_ff >> 1) + bit_val;
         end else begin
            res_in = res_ff >> 1;
         end
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[7:0];

endmodule

`default_nettype wire

// ===== rtl/drvg_datapath.sv =====
// ----------------------------------------------------------------------------
// drvg_datapath: tile store, map size registers and reveal arithmetic
// Holds one row of tiles per memory word, performs whole-store sweeps as a
// read-modify-write pipeline, widens a disc row by row and answers queries.
// ----------------------------------------------------------------------------
`default_nettype none

module drvg_datapath #(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire drvg_pkg::ctrl_cmd_type           cmd,
   output drvg_pkg::dp_status_type               status,
   input  wire logic [drvg_pkg::POS_W-1:0]       req_pos_row,
   input  wire logic [drvg_pkg::POS_W-1:0]       req_pos_col,
   input  wire logic [drvg_pkg::RAD_W-1:0]       req_radius,
   input  wire logic                             csr_write_en,
   input  wire logic [drvg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [drvg_pkg::CSR_W-1:0]       csr_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [drvg_pkg::LVL_W-1:0]            rsp_visibility,
   output logic                                  rsp_is_visible,
   output logic                                  rsp_is_explored
);

   localparam int RowAw  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ColAw  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AwMax  = (RowAw > ColAw) ? RowAw : ColAw;
   localparam int CoordW = ((AwMax > 9) ? AwMax : 9) + 1;
   localparam int RowW   = drvg_pkg::LVL_W * MAX_COLS;
   localparam logic [CoordW-1:0] MaxRowsC = CoordW'(MAX_ROWS);
   localparam logic [CoordW-1:0] MaxColsC = CoordW'(MAX_COLS);
   localparam logic [CoordW-1:0] LastRowC = CoordW'(MAX_ROWS - 1);

   logic [drvg_pkg::CSR_W-1:0]   map_width_ff, map_width_in;
   logic [drvg_pkg::CSR_W-1:0]   map_height_ff, map_height_in;
   logic [drvg_pkg::POS_W-1:0]   cr_ff, cc_ff;
   logic [drvg_pkg::RAD_W-1:0]   rad_ff;
   logic [CoordW-1:0]            row_cnt_ff, row_cnt_in;
   logic [CoordW-1:0]            rhi_ff;
   logic [15:0]                  r2_ff, dr_sq_ff;
   logic                         pend_ff, pend_in;
   drvg_pkg::wmode_type          pend_mode_ff;
   logic [RowAw-1:0]             pend_row_ff;
   logic [RowW-1:0]              rd_data_ff;
   logic [RowW-1:0]              mem [MAX_ROWS];
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [drvg_pkg::LVL_W-1:0]   rsp_lvl_ff;

   logic [CoordW-1:0] eff_rows, eff_cols, rows_m1, cols_m1;
   logic [CoordW-1:0] height_ext, width_ext, cr_ext, cc_ext, rad_ext;
   logic [CoordW-1:0] rlo, rhi_raw, dr_full, lo, hi_raw, hi, w_ext, cpos;
   logic              map_empty, in_map;
   logic [7:0]        dr, root;
   logic              sqrt_busy;
   logic [RowW-1:0]   sweep_row, reveal_row, wr_data;
   logic [RowAw-1:0]  rd_addr, wr_addr;
   logic              mem_we;
   logic [ColAw-1:0]  col_idx;
   logic [drvg_pkg::LVL_W-1:0] tile_q, lvl_q, tile_s;

   always_comb begin
      height_ext = CoordW'(map_height_ff);
      width_ext  = CoordW'(map_width_ff);
      eff_rows   = (height_ext > MaxRowsC) ? MaxRowsC : height_ext;
      eff_cols   = (width_ext > MaxColsC) ? MaxColsC : width_ext;
      rows_m1    = eff_rows - CoordW'(1);
      cols_m1    = eff_cols - CoordW'(1);
      map_empty  = (eff_rows == '0) || (eff_cols == '0);
      cr_ext     = CoordW'(cr_ff);
      cc_ext     = CoordW'(cc_ff);
      rad_ext    = CoordW'(rad_ff);
      rlo        = (cr_ext > rad_ext) ? (cr_ext - rad_ext) : '0;
      rhi_raw    = cr_ext + rad_ext;
      dr_full    = (row_cnt_ff > cr_ext) ? (row_cnt_ff - cr_ext) : (cr_ext - row_cnt_ff);
      dr         = dr_full[7:0];
      w_ext      = CoordW'(root);
      lo         = (cc_ext > w_ext) ? (cc_ext - w_ext) : '0;
      hi_raw     = cc_ext + w_ext;
      hi         = (hi_raw > cols_m1) ? cols_m1 : hi_raw;
   end

   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            drvg_pkg::CSR_MAP_WIDTH:  map_width_in  = csr_data;
            drvg_pkg::CSR_MAP_HEIGHT: map_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      row_cnt_in = row_cnt_ff;
      unique case (cmd.row_op)
         drvg_pkg::ROW_HOLD:     row_cnt_in = row_cnt_ff;
         drvg_pkg::ROW_ZERO:     row_cnt_in = '0;
         drvg_pkg::ROW_LOAD_POS: row_cnt_in = CoordW'(req_pos_row);
         drvg_pkg::ROW_LOAD_LO:  row_cnt_in = rlo;
         drvg_pkg::ROW_INC:      row_cnt_in = row_cnt_ff + CoordW'(1);
         default:                row_cnt_in = row_cnt_ff;
      endcase
   end

   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         tile_s = rd_data_ff[c*drvg_pkg::LVL_W +: drvg_pkg::LVL_W];
         case (pend_mode_ff)
            drvg_pkg::WM_CLEAR:  tile_s = drvg_pkg::LVL_UNEXPLORED;
            drvg_pkg::WM_FILL:   tile_s = drvg_pkg::LVL_VISIBLE;
            drvg_pkg::WM_DEMOTE: begin
               if (tile_s == drvg_pkg::LVL_VISIBLE) begin
                  tile_s = drvg_pkg::LVL_EXPLORED;
               end
            end
            default: ;
         endcase
         sweep_row[c*drvg_pkg::LVL_W +: drvg_pkg::LVL_W] = tile_s;
      end
   end

   always_comb begin
      reveal_row = rd_data_ff;
      for (int c = 0; c < MAX_COLS; c++) begin
         cpos = CoordW'(c);
         if ((cpos >= lo) && (cpos <= hi)) begin
            reveal_row[c*drvg_pkg::LVL_W +: drvg_pkg::LVL_W] = drvg_pkg::LVL_VISIBLE;
         end
      end
   end

   always_comb begin
      rd_addr = row_cnt_ff[RowAw-1:0];
      mem_we  = cmd.rev_write || pend_ff;
      wr_addr = cmd.rev_write ? row_cnt_ff[RowAw-1:0] : pend_row_ff;
      wr_data = cmd.rev_write ? reveal_row : sweep_row;
      pend_in = cmd.rd_en && (cmd.wmode != drvg_pkg::WM_NONE);
   end

   always_comb begin
      col_idx = cc_ext[ColAw-1:0];
      tile_q  = rd_data_ff[{col_idx, 1'b0} +: drvg_pkg::LVL_W];
      in_map  = (cr_ext < eff_rows) && (cc_ext < eff_cols);
      lvl_q   = in_map ? tile_q : drvg_pkg::LVL_UNEXPLORED;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= drvg_pkg::MAP_SIZE_RESET;
         map_height_ff <= drvg_pkg::MAP_SIZE_RESET;
         row_cnt_ff    <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
         row_cnt_ff    <= row_cnt_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cr_ff  <= req_pos_row;
         cc_ff  <= req_pos_col;
         rad_ff <= req_radius;
      end
      if (cmd.rev_setup) begin
         r2_ff  <= {8'd0, rad_ff} * {8'd0, rad_ff};
         rhi_ff <= (rhi_raw > rows_m1) ? rows_m1 : rhi_raw;
      end
      if (cmd.dr_load) begin
         dr_sq_ff <= {8'd0, dr} * {8'd0, dr};
      end
      if (cmd.rsp_load) begin
         rsp_lvl_ff <= lvl_q;
      end
      pend_mode_ff <= cmd.wmode;
      pend_row_ff  <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   drvg_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (r2_ff - dr_sq_ff),
      .busy     (sqrt_busy),
      .root     (root)
   );

   always_comb begin
      status.sweep_last = (row_cnt_ff == LastRowC);
      status.rev_done   = map_empty || (row_cnt_ff > rhi_ff);
      status.sqrt_busy  = sqrt_busy;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_visibility  = rsp_lvl_ff;
   assign rsp_is_visible  = (rsp_lvl_ff == drvg_pkg::LVL_VISIBLE);
   assign rsp_is_explored = (rsp_lvl_ff == drvg_pkg::LVL_EXPLORED) ||
                            (rsp_lvl_ff == drvg_pkg::LVL_VISIBLE);

endmodule

`default_nettype wire

// ===== rtl/drvg_ctrl.sv =====
// ----------------------------------------------------------------------------
// drvg_ctrl: request sequencer
// Accepts one request at a time and steps the datapath through sweeps,
// row-by-row disc reveals and tile queries.
// ----------------------------------------------------------------------------
`default_nettype none

module drvg_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [drvg_pkg::REQ_W-1:0]   req_type,
   input  wire drvg_pkg::dp_status_type      status,
   output drvg_pkg::ctrl_cmd_type            cmd
);

   drvg_pkg::state_type state_ff, state_in;
   drvg_pkg::wmode_type mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drvg_pkg::ST_SWEEP;
         mode_ff  <= drvg_pkg::WM_CLEAR;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      req_ready      = 1'b0;
      cmd.accept     = 1'b0;
      cmd.row_op     = drvg_pkg::ROW_HOLD;
      cmd.rd_en      = 1'b0;
      cmd.wmode      = drvg_pkg::WM_NONE;
      cmd.rev_setup  = 1'b0;
      cmd.dr_load    = 1'b0;
      cmd.sqrt_start = 1'b0;
      cmd.rev_write  = 1'b0;
      cmd.rsp_load   = 1'b0;
      unique case (state_ff)
         drvg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_type)
                  drvg_pkg::REQ_BEGIN_FRAME: begin
                     cmd.row_op = drvg_pkg::ROW_ZERO;
                     mode_in    = drvg_pkg::WM_DEMOTE;
                     state_in   = drvg_pkg::ST_SWEEP;
                  end
                  drvg_pkg::REQ_REVEAL_ALL: begin
                     cmd.row_op = drvg_pkg::ROW_ZERO;
                     mode_in    = drvg_pkg::WM_FILL;
                     state_in   = drvg_pkg::ST_SWEEP;
                  end
                  drvg_pkg::REQ_CLEAR: begin
                     cmd.row_op = drvg_pkg::ROW_ZERO;
                     mode_in    = drvg_pkg::WM_CLEAR;
                     state_in   = drvg_pkg::ST_SWEEP;
                  end
                  drvg_pkg::REQ_REVEAL: begin
                     state_in = drvg_pkg::ST_REV_SETUP;
                  end
                  drvg_pkg::REQ_QUERY: begin
                     cmd.row_op = drvg_pkg::ROW_LOAD_POS;
                     state_in   = drvg_pkg::ST_Q_READ;
                  end
                  default: ;
               endcase
            end
         end
         drvg_pkg::ST_SWEEP: begin
            cmd.rd_en = 1'b1;
            cmd.wmode = mode_ff;
            if (status.sweep_last) begin
               state_in = drvg_pkg::ST_DRAIN;
            end else begin
               cmd.row_op = drvg_pkg::ROW_INC;
            end
         end
         drvg_pkg::ST_DRAIN: begin
            state_in = drvg_pkg::ST_IDLE;
         end
         drvg_pkg::ST_REV_SETUP: begin
            cmd.rev_setup = 1'b1;
            cmd.row_op    = drvg_pkg::ROW_LOAD_LO;
            state_in      = drvg_pkg::ST_REV_ROW;
         end
         drvg_pkg::ST_REV_ROW: begin
            if (status.rev_done) begin
               state_in = drvg_pkg::ST_IDLE;
            end else begin
               cmd.dr_load = 1'b1;
               cmd.rd_en   = 1'b1;
               state_in    = drvg_pkg::ST_REV_SQRT;
            end
         end
         drvg_pkg::ST_REV_SQRT: begin
            cmd.sqrt_start = 1'b1;
            state_in       = drvg_pkg::ST_REV_WAIT;
         end
         drvg_pkg::ST_REV_WAIT: begin
            if (!status.sqrt_busy) begin
               state_in = drvg_pkg::ST_REV_WRITE;
            end
         end
         drvg_pkg::ST_REV_WRITE: begin
            cmd.rev_write = 1'b1;
            cmd.row_op    = drvg_pkg::ROW_INC;
            state_in      = drvg_pkg::ST_REV_ROW;
         end
         drvg_pkg::ST_Q_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = drvg_pkg::ST_Q_RESP;
         end
         drvg_pkg::ST_Q_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = drvg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = drvg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/disk_reveal_visibility_grid.sv =====
// ----------------------------------------------------------------------------
// disk_reveal_visibility_grid: fog-of-war tile visibility store
// Keeps an unexplored, explored or visible level for every tile and applies
// frame, reveal, fill, clear and query requests one at a time.
//
//   Channel   Direction  Handshake                 Payload
//   req       in         req_valid / req_ready     req_type, req_pos_row,
//                                                  req_pos_col, req_radius
//   rsp       out        rsp_valid / rsp_ready     rsp_visibility,
//                                                  rsp_is_visible, rsp_is_explored
//   csr       in         csr_write_en              csr_index, csr_data
//
// Begin frame, reveal all and clear sweep every row of the tile memory, with
// one row read and one row write per cycle. A reveal works the disc row by
// row, each row waiting on the bit-serial square root.
// After reset a clearing pass runs with req_ready low.
// A waiting response does not block the next request, only the next query.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_reveal_visibility_grid #(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [drvg_pkg::REQ_W-1:0]       req_type,
   input  wire logic [drvg_pkg::POS_W-1:0]       req_pos_row,
   input  wire logic [drvg_pkg::POS_W-1:0]       req_pos_col,
   input  wire logic [drvg_pkg::RAD_W-1:0]       req_radius,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [drvg_pkg::LVL_W-1:0]            rsp_visibility,
   output logic                                  rsp_is_visible,
   output logic                                  rsp_is_explored,
   input  wire logic                             csr_write_en,
   input  wire logic [drvg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [drvg_pkg::CSR_W-1:0]       csr_data
);

   drvg_pkg::ctrl_cmd_type  cmd;
   drvg_pkg::dp_status_type status;

   drvg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .status    (status),
      .cmd       (cmd)
   );

   drvg_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_pos_row     (req_pos_row),
      .req_pos_col     (req_pos_col),
      .req_radius      (req_radius),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_visibility  (rsp_visibility),
      .rsp_is_visible  (rsp_is_visible),
      .rsp_is_explored (rsp_is_explored)
   );

endmodule

`default_nettype wire

// ===== rtl/drvg_checker.sv =====
// ----------------------------------------------------------------------------
// drvg_checker: port-level checks for the visibility grid
// Watches the request and response channels and flags behavior that the
// block must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module drvg_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_ready,
   input  wire logic [drvg_pkg::REQ_W-1:0]   req_type,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire logic [drvg_pkg::LVL_W-1:0]   rsp_visibility,
   input  wire logic                         rsp_is_visible,
   input  wire logic                         rsp_is_explored
);

   // The clearing pass keeps the request side closed right after reset.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted during the clearing pass");

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_visibility) && $stable(rsp_is_visible) &&
          $stable(rsp_is_explored)))
      else $error("stalled response changed");

   // The flags always agree with the reported level.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_is_visible == (rsp_visibility == drvg_pkg::LVL_VISIBLE)) &&
          (rsp_is_explored == ((rsp_visibility == drvg_pkg::LVL_EXPLORED) ||
                               (rsp_visibility == drvg_pkg::LVL_VISIBLE)))))
      else $error("response flags disagree with level");

   // Only a query produces a response transfer.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_type != drvg_pkg::REQ_QUERY) && !rsp_valid)
         |=> !rsp_valid)
      else $error("response without a query");

endmodule

bind disk_reveal_visibility_grid drvg_checker u_drvg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_type        (req_type),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_visibility  (rsp_visibility),
   .rsp_is_visible  (rsp_is_visible),
   .rsp_is_explored (rsp_is_explored)
);

`default_nettype wire
